/* rtl/lts_pkg.sv */
// Shared types, codes and helpers for the connection slot cache.
package lts_pkg;

    localparam int ID_BITS    = 16;
    localparam int TIME_BITS  = 32;
    localparam int SIU_W      = 4;
    localparam int RES_SLOT_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SLOTS_DEF  = 8;

    localparam logic [SIU_W-1:0]     SIU_RESET     = 4'd8;
    localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = 32'd300;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;

    typedef enum logic [1:0] {
        KIND_CACHE = 2'd0,
        KIND_USE   = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_FLUSH = 2'd3
    } kind_e;

    typedef enum logic [2:0] {
        EV_EVICTED  = 3'd0,
        EV_INSERTED = 3'd1,
        EV_PRESENT  = 3'd2,
        EV_DISABLED = 3'd3,
        EV_DONE     = 3'd4
    } event_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_EVICT,
        ST_INSERT,
        ST_FIN
    } state_e;

    typedef struct packed {
        kind_e                kind;
        logic [ID_BITS-1:0]   conn_id;
        logic [TIME_BITS-1:0] now_time;
        logic [TIME_BITS-1:0] use_time;
        logic                 send_quit;
        logic [ID_BITS-1:0]   keep_id;
        logic                 keep_valid;
    } req_t;

    typedef struct packed {
        event_e                event_res;
        logic [RES_SLOT_W-1:0] slot;
        logic [ID_BITS-1:0]    victim_id;
        logic                  quit_needed;
        logic                  last;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } ev_t;

    typedef struct packed {
        logic                 valid;
        logic                 has_best;
        logic                 best_free;
        logic                 best_valid;
        logic [ID_BITS-1:0]   best_conn;
        logic [TIME_BITS-1:0] best_lu;
        logic                 found;
    } scan_t;

    function automatic res_t make_res(event_e ev, logic [RES_SLOT_W-1:0] slot,
                                      logic [ID_BITS-1:0] id, logic quit, logic last);
        res_t r;
        r.event_res   = ev;
        r.slot        = slot;
        r.victim_id   = id;
        r.quit_needed = quit;
        r.last        = last;
        return r;
    endfunction

endpackage

/* rtl/lts_cell.sv */
// One slot cell: holds a slot's entry and updates the scan item passing through.
module lts_cell import lts_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IDX   = 0
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   adv,
    input  logic                                   active,
    input  req_t                                   req,
    input  logic [TIME_BITS-1:0]                   idle_timeout,
    input  scan_t                                  pkt_in,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] bidx_in,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] fidx_in,
    output scan_t                                  pkt_out,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] bidx_out,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] fidx_out,
    output ev_t                                    ev,
    input  logic                                   ins_we,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ins_idx
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0]     IDX_CODE = SLOT_W'(IDX);
    localparam logic [RES_SLOT_W-1:0] RES_CODE = RES_SLOT_W'(IDX);

    scan_t                pkt_reg, pkt_next;
    logic [SLOT_W-1:0]    bidx_reg, bidx_next;
    logic [SLOT_W-1:0]    fidx_reg, fidx_next;
    logic                 valid_reg, valid_next;
    logic                 closed_reg, closed_next;
    logic [ID_BITS-1:0]   conn_reg, conn_next;
    logic [TIME_BITS-1:0] lu_reg, lu_next;

    logic match, expired, spared, free;

    always_comb begin
        pkt_next    = pkt_in;
        bidx_next   = bidx_in;
        fidx_next   = fidx_in;
        valid_next  = valid_reg;
        closed_next = closed_reg;
        conn_next   = conn_reg;
        lu_next     = lu_reg;
        ev          = '0;
        match   = valid_reg && (conn_reg == req.conn_id);
        expired = (req.now_time > lu_reg) && ((req.now_time - lu_reg) > idle_timeout);
        spared  = req.keep_valid && (conn_reg == req.keep_id);
        free    = !valid_reg || closed_reg;
        if (adv && pkt_in.valid && active) begin
            case (req.kind)
                KIND_CACHE: begin
                    if (free) begin
                        pkt_next.has_best   = 1'b1;
                        pkt_next.best_free  = 1'b1;
                        pkt_next.best_valid = valid_reg;
                        pkt_next.best_conn  = conn_reg;
                        bidx_next           = IDX_CODE;
                    end else if ((conn_reg != req.conn_id) && expired) begin
                        ev.valid            = 1'b1;
                        ev.res              = make_res(EV_EVICTED, RES_CODE, conn_reg,
                                                       1'b1, 1'b0);
                        valid_next          = 1'b0;
                        closed_next         = 1'b0;
                        pkt_next.has_best   = 1'b1;
                        pkt_next.best_free  = 1'b1;
                        pkt_next.best_valid = 1'b0;
                        bidx_next           = IDX_CODE;
                    end else if (!pkt_in.has_best ||
                                 (!pkt_in.best_free && (lu_reg < pkt_in.best_lu))) begin
                        pkt_next.has_best   = 1'b1;
                        pkt_next.best_free  = 1'b0;
                        pkt_next.best_valid = 1'b1;
                        pkt_next.best_conn  = conn_reg;
                        pkt_next.best_lu    = lu_reg;
                        bidx_next           = IDX_CODE;
                    end
                    if (match && !pkt_in.found) begin
                        pkt_next.found = 1'b1;
                        fidx_next      = IDX_CODE;
                    end
                end
                KIND_USE, KIND_CLOSE: begin
                    if (match && !pkt_in.found) begin
                        pkt_next.found = 1'b1;
                        fidx_next      = IDX_CODE;
                        if (req.kind == KIND_USE) begin
                            lu_next = req.use_time;
                        end else begin
                            closed_next = 1'b1;
                        end
                    end
                end
                KIND_FLUSH: begin
                    if (valid_reg && !spared) begin
                        ev.valid    = 1'b1;
                        ev.res      = make_res(EV_EVICTED, RES_CODE, conn_reg,
                                               req.send_quit && !closed_reg, 1'b0);
                        valid_next  = 1'b0;
                        closed_next = 1'b0;
                    end
                end
                default: begin
                    pkt_next = pkt_in;
                end
            endcase
        end
        if (ins_we && (ins_idx == IDX_CODE)) begin
            valid_next  = 1'b1;
            closed_next = 1'b0;
            conn_next   = req.conn_id;
            lu_next     = req.use_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_reg.valid <= 1'b0;
            valid_reg     <= 1'b0;
            closed_reg    <= 1'b0;
        end else begin
            if (adv) begin
                pkt_reg  <= pkt_next;
                bidx_reg <= bidx_next;
                fidx_reg <= fidx_next;
            end
            valid_reg  <= valid_next;
            closed_reg <= closed_next;
            conn_reg   <= conn_next;
            lu_reg     <= lu_next;
        end
    end

    assign pkt_out  = pkt_reg;
    assign bidx_out = bidx_reg;
    assign fidx_out = fidx_reg;

endmodule

/* rtl/lts_ctrl.sv */
// Request sequencer: launches the scan, finishes each request and drives results.
module lts_ctrl import lts_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  req_t                                   s_item,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output res_t                                   m_item,
    input  logic                                   disabled,
    output logic                                   adv,
    output logic                                   launch,
    output req_t                                   req,
    input  scan_t                                  exit_pkt,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] exit_bidx,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] exit_fidx,
    input  ev_t                                    cell_ev,
    output logic                                   ins_we,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ins_idx
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    state_e             state_reg, state_next;
    logic               launch_reg, launch_next;
    req_t               req_reg, req_next;
    res_t               fin_reg, fin_next;
    logic [SLOT_W-1:0]  bidx_reg, bidx_next;
    logic [ID_BITS-1:0] bconn_reg, bconn_next;
    logic               bquit_reg, bquit_next;
    logic               m_valid_reg, m_valid_next;
    res_t               m_item_reg, m_item_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        launch_next  = launch_reg && !out_free;
        req_next     = req_reg;
        fin_next     = fin_reg;
        bidx_next    = bidx_reg;
        bconn_next   = bconn_reg;
        bquit_next   = bquit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        ins_we       = 1'b0;
        if (cell_ev.valid) begin
            m_valid_next = 1'b1;
            m_item_next  = cell_ev.res;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_item;
                    if ((s_item.kind == KIND_CACHE) && disabled) begin
                        fin_next   = make_res(EV_DISABLED, '0, '0, 1'b0, 1'b1);
                        state_next = ST_FIN;
                    end else begin
                        launch_next = 1'b1;
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (exit_pkt.valid) begin
                    bidx_next  = exit_bidx;
                    bconn_next = exit_pkt.best_conn;
                    bquit_next = !exit_pkt.best_free;
                    case (req_reg.kind)
                        KIND_CACHE: begin
                            if (exit_pkt.found) begin
                                fin_next   = make_res(EV_PRESENT, RES_SLOT_W'(exit_fidx),
                                                      req_reg.conn_id, 1'b0, 1'b1);
                                state_next = ST_FIN;
                            end else if (exit_pkt.best_valid) begin
                                state_next = ST_EVICT;
                            end else begin
                                state_next = ST_INSERT;
                            end
                        end
                        KIND_USE, KIND_CLOSE: begin
                            fin_next = make_res(EV_DONE,
                                                exit_pkt.found ? RES_SLOT_W'(exit_fidx) : '0,
                                                req_reg.conn_id, 1'b0, 1'b1);
                            state_next = ST_FIN;
                        end
                        KIND_FLUSH: begin
                            fin_next   = make_res(EV_DONE, '0, '0, 1'b0, 1'b1);
                            state_next = ST_FIN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EVICT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = make_res(EV_EVICTED, RES_SLOT_W'(bidx_reg), bconn_reg,
                                            bquit_reg, 1'b0);
                    state_next   = ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = make_res(EV_INSERTED, RES_SLOT_W'(bidx_reg),
                                            req_reg.conn_id, 1'b0, 1'b1);
                    ins_we       = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = fin_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        fin_reg    <= fin_next;
        bidx_reg   <= bidx_next;
        bconn_reg  <= bconn_next;
        bquit_reg  <= bquit_next;
        m_item_reg <= m_item_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign adv     = out_free;
    assign launch  = launch_reg;
    assign req     = req_reg;
    assign ins_idx = bidx_reg;

endmodule

/* rtl/lru_timeout_slot_cache.sv */
// Connection slot cache with LRU replacement and idle timeout, built as a chain of slot cells.
// Requests are taken one at a time: a request runs the scan through the cells, then the final
// result follows; a victim is evicted before the insert, and a cache request while disabled
// gets its result without a scan. The scan item walks the cells one slot per cycle while no
// result is held; each held result stalls the scan.
// Reset (aresetn low, synchronous): all slots empty and open, slots_in_use 8, idle_timeout 300.
module lru_timeout_slot_cache import lts_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output res_t                  m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SIU_W-1:0]     siu_reg;
    logic [TIME_BITS-1:0] timeout_reg;

    scan_t             pkt_w  [SLOTS+1];
    logic [SLOT_W-1:0] bidx_w [SLOTS+1];
    logic [SLOT_W-1:0] fidx_w [SLOTS+1];
    ev_t               ev_w   [SLOTS];
    logic [SLOTS-1:0]  active;
    ev_t               cell_ev;

    logic              adv, launch, ins_we;
    logic [SLOT_W-1:0] ins_idx;
    req_t              req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            siu_reg     <= SIU_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SLOTS_IN_USE: siu_reg     <= cfg_data[SIU_W-1:0];
                CFG_IDLE_TIMEOUT: timeout_reg <= cfg_data[TIME_BITS-1:0];
                default: begin
                    siu_reg <= siu_reg;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb begin
        pkt_w[0]       = '0;
        pkt_w[0].valid = launch;
    end
    assign bidx_w[0] = '0;
    assign fidx_w[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        assign active[g] = (32'(siu_reg) > g);

        lts_cell #(
            .SLOTS (SLOTS),
            .IDX   (g)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .adv          (adv),
            .active       (active[g]),
            .req          (req),
            .idle_timeout (timeout_reg),
            .pkt_in       (pkt_w[g]),
            .bidx_in      (bidx_w[g]),
            .fidx_in      (fidx_w[g]),
            .pkt_out      (pkt_w[g+1]),
            .bidx_out     (bidx_w[g+1]),
            .fidx_out     (fidx_w[g+1]),
            .ev           (ev_w[g]),
            .ins_we       (ins_we),
            .ins_idx      (ins_idx)
        );
    end

    always_comb begin
        cell_ev = '0;
        for (int j = 0; j < SLOTS; j++) begin
            cell_ev = ev_t'(cell_ev | ev_w[j]);
        end
    end

    lts_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .disabled  (siu_reg == '0),
        .adv       (adv),
        .launch    (launch),
        .req       (req),
        .exit_pkt  (pkt_w[SLOTS]),
        .exit_bidx (bidx_w[SLOTS]),
        .exit_fidx (fidx_w[SLOTS]),
        .cell_ev   (cell_ev),
        .ins_we    (ins_we),
        .ins_idx   (ins_idx)
    );

endmodule
